### rtl/strm_pkg.sv
package strm_pkg;

	// fixed field widths
	localparam int POS_W = 11;
	localparam int VAL_W = 32;

	localparam int MAX_LEAVES_DEF = 1024;

	localparam logic [POS_W-1:0] LEAF_COUNT_RST = 11'd1024;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic signed [VAL_W-1:0] EMPTY_SENTINEL = 32'sh3f3f3f3f;
	localparam logic signed [VAL_W-1:0] ACC_INIT       = 32'sh7fffffff;

	typedef struct packed {
		logic rd;
		logic wr;
	} ram_cmd_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

endpackage

### rtl/strm_node_ram.sv
module strm_node_ram #(
	parameter int NODE_DEPTH = 4096,
	parameter int AW         = 12
) (
	input  logic                           clk,
	input  strm_pkg::ram_cmd_t             cmd,
	input  logic [AW-1:0]                  rd_addr,
	input  logic [AW-1:0]                  wr_addr,
	input  logic signed [strm_pkg::VAL_W-1:0] wr_data,
	output logic signed [strm_pkg::VAL_W-1:0] rd_data
);
	import strm_pkg::*;

	logic signed [VAL_W-1:0] mem [NODE_DEPTH];
	logic signed [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/strm_stack.sv
module strm_stack #(
	parameter int EW    = 34,
	parameter int STK_D = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  strm_pkg::stk_cmd_t   cmd,
	input  logic [EW-1:0]        push_node,
	output logic [EW-1:0]        top_node,
	output logic                 empty
);
	import strm_pkg::*;

	localparam int IW   = (STK_D > 1) ? $clog2(STK_D) : 1;
	localparam int PTRW = $clog2(STK_D + 1);

	logic [EW-1:0]   ent_q [STK_D];
	logic [PTRW-1:0] ptr_q;
	logic [PTRW-1:0] top_ptr;

	assign top_ptr  = ptr_q - PTRW'(1);
	assign top_node = ent_q[top_ptr[IW-1:0]];
	assign empty    = (ptr_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.push) begin
			ptr_q <= ptr_q + PTRW'(1);
		end else if (cmd.pop) begin
			ptr_q <= top_ptr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ent_q[ptr_q[IW-1:0]] <= push_node;
		end
	end

endmodule

### rtl/strm_ctrl.sv
module strm_ctrl #(
	parameter int AW         = 12,
	parameter int NODE_DEPTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              opcode,
	input  logic [strm_pkg::POS_W-1:0]        position_or_low,
	input  logic [strm_pkg::POS_W-1:0]        range_high,
	input  logic signed [strm_pkg::VAL_W-1:0] new_value,
	input  logic [strm_pkg::POS_W-1:0]        eff_n,
	output logic                              busy,
	output logic                              done,
	output logic signed [strm_pkg::VAL_W-1:0] min_value,
	// node memory
	output strm_pkg::ram_cmd_t                ram_cmd,
	output logic [AW-1:0]                     ram_rd_addr,
	output logic [AW-1:0]                     ram_wr_addr,
	output logic signed [strm_pkg::VAL_W-1:0] ram_wr_data,
	input  logic signed [strm_pkg::VAL_W-1:0] ram_rd_data,
	// pending right children
	output strm_pkg::stk_cmd_t                stk_cmd,
	output logic [AW+2*strm_pkg::POS_W-1:0]   stk_push_node,
	input  logic [AW+2*strm_pkg::POS_W-1:0]   stk_top_node,
	input  logic                              stk_empty
);
	import strm_pkg::*;

	localparam int NODE_DEPTH_M1 = NODE_DEPTH - 1;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_WDN  = 3'd2;
	localparam logic [2:0] ST_WUP  = 3'd3;
	localparam logic [2:0] ST_QVIS = 3'd4;
	localparam logic [2:0] ST_QFIN = 3'd5;

	localparam logic [AW-1:0] ROOT = AW'(1);

	logic [2:0]              state_q;
	logic [AW-1:0]           k_q;
	logic [POS_W-1:0]        l_q, r_q, lo_q, hi_q;
	logic signed [VAL_W-1:0] val_q, acc_q;
	logic                    rd_pend_q;
	logic                    done_q;
	logic signed [VAL_W-1:0] min_value_q;

	logic [POS_W-1:0]        mid, a_lo, b_hi;
	logic [AW-1:0]           k_left, k_right, k_par;
	logic                    covered, go_l, go_r, accept, wr_ok;
	logic signed [VAL_W-1:0] up_min, acc_min;

	assign mid     = l_q + ((r_q - l_q) >> 1);
	assign covered = (lo_q <= l_q) && (r_q <= hi_q);
	assign go_l    = (lo_q <= mid);
	assign go_r    = (hi_q > mid);
	assign k_left  = {k_q[AW-2:0], 1'b0};
	assign k_right = {k_q[AW-2:0], 1'b1};
	assign k_par   = k_q >> 1;
	assign up_min  = (val_q < ram_rd_data) ? val_q : ram_rd_data;
	assign acc_min = (acc_q < ram_rd_data) ? acc_q : ram_rd_data;

	assign accept = start && !busy;
	assign a_lo   = (position_or_low == '0) ? POS_W'(1) : position_or_low;
	assign b_hi   = (range_high > eff_n) ? eff_n : range_high;
	assign wr_ok  = (position_or_low != '0) && (position_or_low <= eff_n);

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign min_value = min_value_q;

	assign stk_push_node = {k_right, mid + POS_W'(1), r_q};

	// memory and stack requests
	always_comb begin
		ram_cmd     = '0;
		ram_rd_addr = '0;
		ram_wr_addr = k_q;
		ram_wr_data = val_q;
		stk_cmd     = '0;
		unique case (state_q)
			ST_CLR: begin
				ram_cmd.wr  = 1'b1;
				ram_wr_data = '0;
			end
			ST_WDN: begin
				if (l_q == r_q) begin
					ram_cmd.wr  = 1'b1;
					ram_cmd.rd  = (k_q != ROOT);
					ram_rd_addr = k_q ^ AW'(1);
				end
			end
			ST_WUP: begin
				ram_cmd.wr  = 1'b1;
				ram_wr_addr = k_par;
				ram_wr_data = up_min;
				ram_cmd.rd  = (k_par != ROOT);
				ram_rd_addr = k_par ^ AW'(1);
			end
			ST_QVIS: begin
				if (covered) begin
					ram_cmd.rd  = 1'b1;
					ram_rd_addr = k_q;
					stk_cmd.pop = !stk_empty;
				end else begin
					stk_cmd.push = go_l && go_r;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			k_q       <= '0;
			rd_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_pend_q <= (state_q == ST_QVIS) && covered;
			unique case (state_q)
				ST_CLR: begin
					k_q <= k_q + AW'(1);
					if (k_q == AW'(NODE_DEPTH_M1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						k_q <= ROOT;
						if (opcode == OP_WRITE) begin
							if (wr_ok) begin
								state_q <= ST_WDN;
							end
						end else if (a_lo > b_hi) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_QVIS;
						end
					end
				end
				ST_WDN: begin
					if (l_q == r_q) begin
						state_q <= (k_q == ROOT) ? ST_IDLE : ST_WUP;
					end else if (lo_q <= mid) begin
						k_q <= k_left;
					end else begin
						k_q <= k_right;
					end
				end
				ST_WUP: begin
					k_q <= k_par;
					if (k_par == ROOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_QVIS: begin
					if (covered) begin
						if (stk_empty) begin
							state_q <= ST_QFIN;
						end else begin
							k_q <= stk_top_node[AW+2*POS_W-1:2*POS_W];
						end
					end else if (go_l) begin
						k_q <= k_left;
					end else begin
						k_q <= k_right;
					end
				end
				ST_QFIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			acc_q <= acc_min;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					l_q   <= POS_W'(1);
					r_q   <= eff_n;
					lo_q  <= (opcode == OP_WRITE) ? position_or_low : a_lo;
					hi_q  <= b_hi;
					val_q <= new_value;
					acc_q <= ACC_INIT;
					if (opcode == OP_QUERY) begin
						min_value_q <= EMPTY_SENTINEL;
					end
				end
			end
			ST_WDN: begin
				if (l_q != r_q) begin
					if (lo_q <= mid) begin
						r_q <= mid;
					end else begin
						l_q <= mid + POS_W'(1);
					end
				end
			end
			ST_WUP: begin
				val_q <= up_min;
			end
			ST_QVIS: begin
				if (covered) begin
					if (!stk_empty) begin
						l_q <= stk_top_node[2*POS_W-1:POS_W];
						r_q <= stk_top_node[POS_W-1:0];
					end
				end else if (go_l) begin
					r_q <= mid;
				end else begin
					l_q <= mid + POS_W'(1);
				end
			end
			ST_QFIN: begin
				min_value_q <= acc_min;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/segment_tree_range_min_core.sv
// Channel   Beat marker            Payload
// --------  ---------------------  ------------------------------------------------
// command   start & !busy          opcode, position_or_low, range_high, new_value
// result    done (one cycle)       min_value
// config    leaf_count_we          leaf_count
//
// Write: walks down from the root to the leaf and writes it, then walks back up to the
// root, with one read and one write of the node memory per level on the way up.
// Query: walks the tree node by node, reading each covered node, then folds in the last
// read; an empty range answers in the cycle after the beat. The node memory has one
// read port and one write port.
// Reset: a clearing pass zeroes all 4*MAX_LEAVES nodes, one per cycle; busy stays
// high for those cycles. The result side cannot stall: done is a single-cycle strobe.
module segment_tree_range_min_core #(
	parameter int MAX_LEAVES = strm_pkg::MAX_LEAVES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              opcode,
	input  logic [strm_pkg::POS_W-1:0]        position_or_low,
	input  logic [strm_pkg::POS_W-1:0]        range_high,
	input  logic signed [strm_pkg::VAL_W-1:0] new_value,
	output logic                              done,
	output logic signed [strm_pkg::VAL_W-1:0] min_value,
	input  logic                              leaf_count_we,
	input  logic [strm_pkg::POS_W-1:0]        leaf_count
);
	import strm_pkg::*;

	// node k has children 2k and 2k+1; indices stay below 4n
	localparam int NODE_DEPTH = 4 * MAX_LEAVES;
	localparam int AW         = $clog2(NODE_DEPTH);
	// pending right children never outnumber tree levels
	localparam int STK_D      = $clog2(MAX_LEAVES) + 2;
	localparam int EW         = AW + 2 * POS_W;

	logic [POS_W-1:0]        leaf_count_q;
	logic [POS_W-1:0]        eff_n;

	ram_cmd_t                ram_cmd;
	logic [AW-1:0]           ram_rd_addr, ram_wr_addr;
	logic signed [VAL_W-1:0] ram_wr_data, ram_rd_data;

	stk_cmd_t                stk_cmd;
	logic [EW-1:0]           stk_push_node, stk_top_node;
	logic                    stk_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_count_q <= LEAF_COUNT_RST;
		end else if (leaf_count_we) begin
			leaf_count_q <= leaf_count;
		end
	end

	// zero acts as one, oversize acts as the tree capacity
	always_comb begin
		if (leaf_count_q == '0) begin
			eff_n = POS_W'(1);
		end else if (32'(leaf_count_q) > MAX_LEAVES) begin
			eff_n = POS_W'(MAX_LEAVES);
		end else begin
			eff_n = leaf_count_q;
		end
	end

	strm_ctrl #(
		.AW         (AW),
		.NODE_DEPTH (NODE_DEPTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.opcode          (opcode),
		.position_or_low (position_or_low),
		.range_high      (range_high),
		.new_value       (new_value),
		.eff_n           (eff_n),
		.busy            (busy),
		.done            (done),
		.min_value       (min_value),
		.ram_cmd         (ram_cmd),
		.ram_rd_addr     (ram_rd_addr),
		.ram_wr_addr     (ram_wr_addr),
		.ram_wr_data     (ram_wr_data),
		.ram_rd_data     (ram_rd_data),
		.stk_cmd         (stk_cmd),
		.stk_push_node   (stk_push_node),
		.stk_top_node    (stk_top_node),
		.stk_empty       (stk_empty)
	);

	strm_node_ram #(
		.NODE_DEPTH (NODE_DEPTH),
		.AW         (AW)
	) u_ram (
		.clk     (clk),
		.cmd     (ram_cmd),
		.rd_addr (ram_rd_addr),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_data (ram_rd_data)
	);

	strm_stack #(
		.EW    (EW),
		.STK_D (STK_D)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (stk_cmd),
		.push_node (stk_push_node),
		.top_node  (stk_top_node),
		.empty     (stk_empty)
	);

endmodule

### rtl/strm_checker.sv
module strm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic opcode,
	input logic done
);
	import strm_pkg::*;

	// result only shows once the engine is free
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// writes never answer
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_WRITE) |=> !done)
		else $error("result after write");

	// a query either answers at once or starts walking
	a_query_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == OP_QUERY) |=> (done ^ busy))
		else $error("query neither answered nor started");

	// no result out of nowhere
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a beat");

endmodule

bind segment_tree_range_min_core strm_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.opcode (opcode),
	.done   (done)
);
